// ===== design/smc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smc_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int DATA_W          = 32;
   localparam int GAIN_W          = 31;
   localparam int LIMIT_RESET_INT = 100;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CSR_ADDR_W      = 5;

   typedef enum logic [1:0] {
      LAW_CONSTANT,
      LAW_EXPONENTIAL,
      LAW_POWER,
      LAW_COMBINED
   } law_type;

   typedef enum logic [2:0] {
      REG_LAW,
      REG_SLOPE,
      REG_EPS,
      REG_GAIN,
      REG_PHI,
      REG_LIMIT
   } reg_type;

   typedef struct packed {
      law_type           law;
      logic [GAIN_W-1:0] slope;
      logic [GAIN_W-1:0] eps;
      logic [GAIN_W-1:0] gain;
      logic [GAIN_W-1:0] phi;
      logic [GAIN_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] s;
      logic signed [DATA_W-1:0] ueq;
   } item_type;

endpackage
`default_nettype wire

// ===== design/smc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smc_front #(
   parameter int FRAC_BITS = smc_pkg::FRAC_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  signed [smc_pkg::DATA_W-1:0]  req_error,
   input  wire  signed [smc_pkg::DATA_W-1:0]  req_error_rate,
   input  wire  signed [smc_pkg::DATA_W-1:0]  req_equivalent_drive,
   input  wire         [smc_pkg::GAIN_W-1:0]  slope,
   output logic                               q_valid,
   input  wire                                q_ready,
   output smc_pkg::item_type                  q_item
);

   logic                 v1_ff, v2_ff;
   logic                 ready1, ready2;
   logic signed [63:0]   prod_ff;
   logic signed [31:0]   rate1_ff, ueq1_ff;
   logic signed [31:0]   s2_ff, ueq2_ff;
   logic signed [63:0]   sum_c;
   logic signed [31:0]   s_in;

   assign ready2    = !v2_ff || q_ready;
   assign ready1    = !v1_ff || ready2;
   assign req_ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_valid) begin
         prod_ff  <= $signed({1'b0, slope}) * req_error;
         rate1_ff <= req_error_rate;
         ueq1_ff  <= req_equivalent_drive;
      end
   end

   always_comb begin
      sum_c = 64'(rate1_ff) + (prod_ff >>> FRAC_BITS);
      if (sum_c[63] && !(&sum_c[62:31])) begin
         s_in = 32'sh8000_0000;
      end else if (!sum_c[63] && (|sum_c[62:31])) begin
         s_in = 32'sh7FFF_FFFF;
      end else begin
         s_in = sum_c[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && v1_ff) begin
         s2_ff   <= s_in;
         ueq2_ff <= ueq1_ff;
      end
   end

   assign q_valid    = v2_ff;
   assign q_item.s   = s2_ff;
   assign q_item.ueq = ueq2_ff;

endmodule
`default_nettype wire

// ===== design/smc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smc_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push_valid,
   output logic               push_ready,
   input  smc_pkg::item_type  push_item,
   output logic               pop_valid,
   input  wire                pop_ready,
   output smc_pkg::item_type  pop_item
);

   localparam int DEPTH = smc_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   smc_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic              push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule
`default_nettype wire

// ===== design/smc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smc_back #(
   parameter int FRAC_BITS = smc_pkg::FRAC_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  smc_pkg::cfg_type                  cfg,
   input  wire                               q_valid,
   output logic                              q_ready,
   input  smc_pkg::item_type                 q_item,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic signed [smc_pkg::DATA_W-1:0] rsp_drive,
   output logic                              rsp_clamped
);

   localparam int NR   = (smc_pkg::DATA_W + 1 + FRAC_BITS) / 2;
   localparam int XW   = 2 * NR;
   localparam int RW   = NR + 2;
   localparam int QW   = FRAC_BITS + 1;
   localparam int SVW  = FRAC_BITS + 2;
   localparam int PKW  = 31 + NR;
   localparam int MW   = PKW - FRAC_BITS + 1;
   localparam int PEW  = 32 + SVW;
   localparam int MPW  = MW + SVW;
   localparam int SUMW = 72;
   localparam logic signed [SVW-1:0] SV_ONE = SVW'(1) << FRAC_BITS;

   logic en;

   logic              v_ff   [0:NR];
   logic signed [31:0] s_ff  [0:NR];
   logic signed [31:0] ueq_ff[0:NR];
   logic [31:0]       mag_ff [0:NR];
   logic [31:0]       dr_ff  [0:NR];
   logic [QW-1:0]     dq_ff  [0:NR];
   logic [RW-1:0]     sr_ff  [0:NR];
   logic [NR-1:0]     rt_ff  [0:NR];
   logic [XW-1:0]     sx_ff  [0:NR];

   logic [31:0]       mag_in;

   assign en      = !rsp_valid || rsp_ready;
   assign q_ready = en;
   assign mag_in  = q_item.s[31] ? 32'(-q_item.s) : 32'(q_item.s);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0]   <= q_item.s;
         ueq_ff[0] <= q_item.ueq;
         mag_ff[0] <= mag_in;
         dr_ff[0]  <= mag_in;
         dq_ff[0]  <= '0;
         sr_ff[0]  <= '0;
         rt_ff[0]  <= '0;
         sx_ff[0]  <= XW'({mag_in, {FRAC_BITS{1'b0}}});
      end
   end

   for (genvar i = 1; i <= NR; i++) begin : g_stage
      logic [32:0]   dt_c, dd_c;
      logic          ge_c;
      logic [RW-1:0] st_c, trial_c;

      always_comb begin
         dt_c    = (i == 1) ? {1'b0, dr_ff[i-1]} : {dr_ff[i-1], 1'b0};
         dd_c    = dt_c - 33'(cfg.phi);
         ge_c    = (dt_c >= 33'(cfg.phi));
         st_c    = {sr_ff[i-1][RW-3:0], sx_ff[i-1][XW-1 -: 2]};
         trial_c = {rt_ff[i-1], 2'b01};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[i]   <= s_ff[i-1];
            ueq_ff[i] <= ueq_ff[i-1];
            mag_ff[i] <= mag_ff[i-1];
            sx_ff[i]  <= sx_ff[i-1] << 2;
            if (i <= QW) begin
               dr_ff[i] <= ge_c ? dd_c[31:0] : dt_c[31:0];
               dq_ff[i] <= {dq_ff[i-1][QW-2:0], ge_c};
            end else begin
               dr_ff[i] <= dr_ff[i-1];
               dq_ff[i] <= dq_ff[i-1];
            end
            if (st_c >= trial_c) begin
               sr_ff[i] <= st_c - trial_c;
               rt_ff[i] <= {rt_ff[i-1][NR-2:0], 1'b1};
            end else begin
               sr_ff[i] <= st_c;
               rt_ff[i] <= {rt_ff[i-1][NR-2:0], 1'b0};
            end
         end
      end
   end

   // boundary layer
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [SVW-1:0] sv_in, sv1_ff, sv2_ff;
   logic [NR-1:0]         rt1_ff;
   logic signed [31:0]    s1_ff, ueq1_ff, ueq2_ff, ueq3_ff;
   logic signed [SVW-1:0] q_s;

   always_comb begin
      q_s = $signed(SVW'(dq_ff[NR]));
      if (cfg.phi == '0) begin
         if (s_ff[NR] > 0) begin
            sv_in = SV_ONE;
         end else if (s_ff[NR] < 0) begin
            sv_in = -SV_ONE;
         end else begin
            sv_in = '0;
         end
      end else if (mag_ff[NR] > 32'(cfg.phi)) begin
         sv_in = s_ff[NR][31] ? -SV_ONE : SV_ONE;
      end else begin
         sv_in = s_ff[NR][31] ? -q_s : q_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v_ff[NR];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sv1_ff  <= sv_in;
         rt1_ff  <= rt_ff[NR];
         s1_ff   <= s_ff[NR];
         ueq1_ff <= ueq_ff[NR];
      end
   end

   // products
   logic signed [PEW-1:0] pe_ff;
   logic [PKW-1:0]        pk_ff;
   logic signed [63:0]    ps_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pe_ff   <= $signed({1'b0, cfg.eps}) * sv1_ff;
         pk_ff   <= cfg.gain * rt1_ff;
         ps_ff   <= $signed({1'b0, cfg.gain}) * s1_ff;
         sv2_ff  <= sv1_ff;
         ueq2_ff <= ueq1_ff;
      end
   end

   // power term and shifted terms
   logic signed [MW-1:0]  m_c;
   logic signed [MPW-1:0] mp_ff;
   logic signed [PEW-1:0] a_ff;
   logic signed [63:0]    b_ff;

   assign m_c = $signed({1'b0, pk_ff[PKW-1:FRAC_BITS]});

   always_ff @(posedge clock) begin
      if (en) begin
         mp_ff   <= m_c * sv2_ff;
         a_ff    <= pe_ff >>> FRAC_BITS;
         b_ff    <= (cfg.law == smc_pkg::LAW_COMBINED) ? (ps_ff >>> (FRAC_BITS - 1))
                                                      : (ps_ff >>> FRAC_BITS);
         ueq3_ff <= ueq2_ff;
      end
   end

   // sum
   logic signed [SUMW-1:0] ta_c, tb_c, tm_c, sw_c, sum_ff;

   always_comb begin
      ta_c = SUMW'(a_ff);
      tb_c = SUMW'(b_ff);
      tm_c = SUMW'(mp_ff >>> FRAC_BITS);
      unique case (cfg.law)
         smc_pkg::LAW_CONSTANT:    sw_c = ta_c;
         smc_pkg::LAW_EXPONENTIAL: sw_c = ta_c + tb_c;
         smc_pkg::LAW_POWER:       sw_c = tm_c;
         smc_pkg::LAW_COMBINED:    sw_c = tm_c + ta_c + tb_c;
         default:                  sw_c = ta_c;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= SUMW'(ueq3_ff) + sw_c;
      end
   end

   // clamp and output register
   logic signed [SUMW-1:0] lim_c;
   logic                   out_v_ff, clamped_ff;
   logic signed [31:0]     drive_ff;

   assign lim_c = $signed(SUMW'(cfg.limit));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (sum_ff > lim_c) begin
            drive_ff   <= $signed({1'b0, cfg.limit});
            clamped_ff <= 1'b1;
         end else if (sum_ff < -lim_c) begin
            drive_ff   <= -$signed({1'b0, cfg.limit});
            clamped_ff <= 1'b1;
         end else begin
            drive_ff   <= sum_ff[31:0];
            clamped_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_drive   = drive_ff;
   assign rsp_clamped = clamped_ff;

endmodule
`default_nettype wire

// ===== design/sliding_mode_controller_unit.sv =====
// Throughput: one item per cycle unless rsp_ready stalls it; the square root resolves
// one bit per stage of the back pipeline; the boundary division does so until it is done.
// Reset: synchronous, clears pipeline valids, queue pointers and loads register
// reset values (output limit 100.0); no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sliding_mode_controller_unit #(
   parameter int FRAC_BITS = smc_pkg::FRAC_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  signed [smc_pkg::DATA_W-1:0]     req_error,
   input  wire  signed [smc_pkg::DATA_W-1:0]     req_error_rate,
   input  wire  signed [smc_pkg::DATA_W-1:0]     req_equivalent_drive,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic signed [smc_pkg::DATA_W-1:0]     rsp_drive,
   output logic                                  rsp_clamped,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire         [smc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire         [31:0]                    csr_pwdata,
   output logic        [31:0]                    csr_prdata,
   output logic                                  csr_pready
);

   smc_pkg::cfg_type  cfg_ff;
   smc_pkg::reg_type  idx;
   logic              wr;
   logic              q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   smc_pkg::item_type q_push_item, q_pop_item;

   assign csr_pready = 1'b1;
   assign idx        = smc_pkg::reg_type'(csr_paddr[4:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.law   <= smc_pkg::LAW_CONSTANT;
         cfg_ff.slope <= '0;
         cfg_ff.eps   <= '0;
         cfg_ff.gain  <= '0;
         cfg_ff.phi   <= '0;
         cfg_ff.limit <= smc_pkg::GAIN_W'(smc_pkg::LIMIT_RESET_INT) << FRAC_BITS;
      end else if (wr) begin
         unique case (idx)
            smc_pkg::REG_LAW:   cfg_ff.law   <= smc_pkg::law_type'(csr_pwdata[1:0]);
            smc_pkg::REG_SLOPE: cfg_ff.slope <= csr_pwdata[30:0];
            smc_pkg::REG_EPS:   cfg_ff.eps   <= csr_pwdata[30:0];
            smc_pkg::REG_GAIN:  cfg_ff.gain  <= csr_pwdata[30:0];
            smc_pkg::REG_PHI:   cfg_ff.phi   <= csr_pwdata[30:0];
            smc_pkg::REG_LIMIT: cfg_ff.limit <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         smc_pkg::REG_LAW:   csr_prdata = 32'(cfg_ff.law);
         smc_pkg::REG_SLOPE: csr_prdata = 32'(cfg_ff.slope);
         smc_pkg::REG_EPS:   csr_prdata = 32'(cfg_ff.eps);
         smc_pkg::REG_GAIN:  csr_prdata = 32'(cfg_ff.gain);
         smc_pkg::REG_PHI:   csr_prdata = 32'(cfg_ff.phi);
         smc_pkg::REG_LIMIT: csr_prdata = 32'(cfg_ff.limit);
         default:            csr_prdata = '0;
      endcase
   end

   smc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_error            (req_error),
      .req_error_rate       (req_error_rate),
      .req_equivalent_drive (req_equivalent_drive),
      .slope                (cfg_ff.slope),
      .q_valid              (q_push_valid),
      .q_ready              (q_push_ready),
      .q_item               (q_push_item)
   );

   smc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   smc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_pop_valid),
      .q_ready     (q_pop_ready),
      .q_item      (q_pop_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_drive   (rsp_drive),
      .rsp_clamped (rsp_clamped)
   );

   a_clamp_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clamped |->
         (rsp_drive == $signed({1'b0, cfg_ff.limit})) ||
         (rsp_drive == -$signed({1'b0, cfg_ff.limit})))
      else $error("clamped item not at limit");

   a_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_clamped |->
         (rsp_drive <= $signed({1'b0, cfg_ff.limit})) &&
         (rsp_drive >= -$signed({1'b0, cfg_ff.limit})))
      else $error("unclamped item beyond limit");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   class smc_scoreboard;
      typedef struct {
         logic signed [31:0] drive;
         bit                 clamped;
      } drive_result;

      smc_pkg::law_type law;
      longint      slope, eps, gain, phi, limit;
      drive_result expected_q[$];

      function new();
         law   = smc_pkg::LAW_CONSTANT;
         slope = 0;
         eps   = 0;
         gain  = 0;
         phi   = 0;
         limit = 6553600;
      endfunction

      function longint root_floor(longint x);
         longint r, b;
         r = 0;
         b = longint'(1) << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint boundary_sat(longint s);
         longint one, q, mag;
         one = longint'(1) << 16;
         if (phi == 0) return (s > 0) ? one : ((s < 0) ? -one : 0);
         if (s > phi) return one;
         if (s < -phi) return -one;
         mag = (s < 0) ? -s : s;
         q = (mag << 16) / phi;
         return (s < 0) ? -q : q;
      endfunction

      function void note(logic signed [31:0] e, logic signed [31:0] ed,
                         logic signed [31:0] ueq);
         longint s, sv, mag, root, m, sw, u;
         drive_result r;
         s = longint'(ed) + ((slope * longint'(e)) >>> 16);
         if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
         if (s < -64'sh80000000) s = -64'sh80000000;
         sv   = boundary_sat(s);
         mag  = (s < 0) ? -s : s;
         root = root_floor(mag << 16);
         m    = (gain * root) >>> 16;
         case (law)
            smc_pkg::LAW_CONSTANT:    sw = (eps * sv) >>> 16;
            smc_pkg::LAW_EXPONENTIAL: sw = ((eps * sv) >>> 16) + ((gain * s) >>> 16);
            smc_pkg::LAW_POWER:       sw = (m * sv) >>> 16;
            default:                  sw = ((m * sv) >>> 16) + ((eps * sv) >>> 16)
                                           + ((gain * s) >>> 15);
         endcase
         u = longint'(ueq) + sw;
         r.clamped = 0;
         if (u > limit) begin
            u = limit;
            r.clamped = 1;
         end
         if (u < -limit) begin
            u = -limit;
            r.clamped = 1;
         end
         r.drive = u[31:0];
         expected_q.push_back(r);
      endfunction

      function int check(logic signed [31:0] d, bit cl, output string msg);
         drive_result r;
         int bad;
         bad = 0;
         msg = "";
         if (expected_q.size() == 0) begin
            msg = $sformatf("unexpected result drive=%0d clamped=%0b", d, cl);
            return 1;
         end
         r = expected_q.pop_front();
         if (d !== r.drive) begin
            msg = $sformatf("drive got %0d want %0d", d, r.drive);
            bad++;
         end
         if (cl !== r.clamped) begin
            msg = {msg, $sformatf(" clamped got %0b want %0b", cl, r.clamped)};
            bad++;
         end
         return bad;
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_error = 0;
   logic signed [31:0] req_error_rate = 0;
   logic signed [31:0] req_equivalent_drive = 0;
   logic               rsp_valid;
   logic               rsp_ready = 1;
   logic signed [31:0] rsp_drive;
   logic               rsp_clamped;
   logic               csr_psel = 0;
   logic               csr_penable = 0;
   logic               csr_pwrite = 0;
   logic [smc_pkg::CSR_ADDR_W-1:0] csr_paddr = 0;
   logic [31:0]        csr_pwdata = 0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   smc_scoreboard sb = new();
   int  in_count = 0;
   int  out_count = 0;
   int  errors = 0;
   int  idle_cycles = 0;
   int  clamp_count = 0;
   bit  quiet = 0;
   bit  hold_req = 0;
   localparam int WATCHDOG_LIMIT = 5000;

   sliding_mode_controller_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_error(req_error), .req_error_rate(req_error_rate),
      .req_equivalent_drive(req_equivalent_drive),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_drive(rsp_drive), .rsp_clamped(rsp_clamped),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   task report(string msg);
      errors++;
      $display("mismatch at result %0d: %s", out_count, msg);
   endtask

   always @(posedge clock) begin
      string msg;
      bit    moved;
      moved = 0;
      if (!reset && req_valid && req_ready) begin
         sb.note(req_error, req_error_rate, req_equivalent_drive);
         in_count++;
         moved = 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (sb.check(rsp_drive, rsp_clamped, msg) != 0) report(msg);
         if (rsp_clamped) clamp_count++;
         out_count++;
         moved = 1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // receiver: random stalls, one long hold on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_req = 0;
            rsp_ready <= 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            rsp_ready <= 0;
            repeat (n) @(negedge clock);
            rsp_ready <= 1;
         end
      end
   end

   task send_item(logic signed [31:0] e, logic signed [31:0] ed,
                  logic signed [31:0] ueq);
      int seen;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid            <= 1;
      req_error            <= e;
      req_error_rate       <= ed;
      req_equivalent_drive <= ueq;
      seen = in_count;
      do @(negedge clock); while (in_count == seen);
   endtask

   task drain();
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task write_reg(smc_pkg::reg_type r, logic [31:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= smc_pkg::CSR_ADDR_W'(r) << 2;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task configure(smc_pkg::law_type law, logic [30:0] c, logic [30:0] eps,
                  logic [30:0] k, logic [30:0] phi, logic [30:0] lim);
      write_reg(smc_pkg::REG_LAW, 32'(law));
      write_reg(smc_pkg::REG_SLOPE, 32'(c));
      write_reg(smc_pkg::REG_EPS, 32'(eps));
      write_reg(smc_pkg::REG_GAIN, 32'(k));
      write_reg(smc_pkg::REG_PHI, 32'(phi));
      write_reg(smc_pkg::REG_LIMIT, 32'(lim));
      sb.law   = law;
      sb.slope = c;
      sb.eps   = eps;
      sb.gain  = k;
      sb.phi   = phi;
      sb.limit = lim;
   endtask

   function logic signed [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         3: return $signed($urandom) >>> $urandom_range(0, 31);
         default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
   endfunction

   initial begin
      logic signed [31:0] mx, mn;
      logic [30:0] c, eps, k, phi, lim;
      mx = 32'h7FFFFFFF;
      mn = 32'h80000000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // reset settings
      send_item(32'sh10000, 0, 32'sh7FFFFFFF);
      send_item(0, 0, mn);
      send_item(-5, 3, 1234);
      drain();

      configure(smc_pkg::LAW_COMBINED, 31'h18000, 31'h20000, 31'h10000, 31'h40000,
                31'd6553600);
      send_item(0, 0, 0);
      send_item(mx, mx, mx);
      send_item(mn, mn, mn);
      send_item(mx, mn, 0);
      send_item(mn, mx, 0);
      send_item(0, 32'sh50000, 0);
      send_item(0, -32'sh50000, 0);
      send_item(0, 32'sh40000, 0);
      send_item(0, -32'sh40000, 0);
      send_item(0, 32'sh8000, 0);
      send_item(0, -32'sh8000, 0);
      send_item(32'sh10000, -32'sh18000, 0);
      send_item(0, 1, 32'sh640000);
      send_item(0, -1, -32'sh640000);
      send_item(0, 0, 32'sh640001);
      send_item(0, 0, -32'sh640001);
      send_item(-1, 1, -1);
      drain();

      for (int p = 1; p < 8; p++) begin
         c   = 31'($urandom_range(0, 1 << 18));
         eps = 31'($urandom_range(0, 1 << 22));
         k   = 31'($urandom_range(0, 1 << 20));
         phi = 31'($urandom_range(0, 1 << 20));
         lim = 31'($urandom);
         if (p == 1) begin
            c = 0; eps = 0; k = 0; phi = 0; lim = 31'h7FFFFFFF;
         end
         if (p == 4) begin
            c = '1; eps = '1; k = '1; phi = '1; lim = '1;
         end
         if (p == 5) phi = 0;
         if (p == 7) lim = 0;
         if (p == 3) lim = 31'($urandom_range(0, 1 << 24));
         quiet = (p >= 6);
         configure(smc_pkg::law_type'(p % 4), c, eps, k, phi, lim);
         if (p == 2) begin
            quiet = 1;
            hold_req = 1;
         end
         for (int i = 0; i < 230; i++) begin
            if (p == 2 && i == 120) quiet = 0;
            if (p == 3 && i == 115) drain();
            send_item(pick_value(), pick_value(), pick_value());
         end
         drain();
      end

      if (sb.expected_q.size() != 0) report("results still outstanding at end");
      $display("covered %0d items over all four reaching laws, zero/max gains,", in_count);
      $display("pure-sign and wide boundary layers; %0d results, %0d clamped",
               out_count, clamp_count);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
design/smc_pkg.sv
design/smc_front.sv
design/smc_queue.sv
design/smc_back.sv
design/sliding_mode_controller_unit.sv
test/testbench.sv
